/* rtl/tse_pkg.sv */
// Shared types and constants of the table search engine.
// Used by the channel interfaces and by the top level, the comparator and the sequencer.
package tse_pkg;

   // Fixed field widths of the channels.
   localparam int OPERATION_W = 2;
   localparam int ADDRESS_W   = 8;
   localparam int KEY_W       = 32;
   localparam int POSITION_W  = 8;
   localparam int LENGTH_W    = 9;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 9;

   // Reset value of the table length register.
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = 9'd256;

   // Operation codes carried by a request item.
   typedef enum logic [OPERATION_W-1:0] {
      OP_WRITE   = 2'd0,
      OP_FORWARD = 2'd1,
      OP_REVERSE = 2'd2,
      OP_BINARY  = 2'd3
   } op_type;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_TABLE_LENGTH   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COMPARE_SIGNED = 4'd1;

   // Outcome of the shared key comparator; neither bit set means greater.
   typedef struct packed {
      logic less;
      logic equal;
   } cmp_type;

   // Status the sequencer hands to the result register.
   typedef struct packed {
      logic done;
      logic found;
   } status_type;

endpackage

/* rtl/tse_channels.sv */
// Handshake channel interfaces of the table search engine.
// Depends on tse_pkg for the field widths.
interface search_req_if;
   logic                             valid;
   logic                             ready;
   logic [tse_pkg::OPERATION_W-1:0]  operation;
   logic [tse_pkg::ADDRESS_W-1:0]    address;
   logic [tse_pkg::KEY_W-1:0]        key;
   modport source (output valid, operation, address, key, input ready);
   modport sink   (input valid, operation, address, key, output ready);
endinterface

interface search_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             found;
   logic [tse_pkg::POSITION_W-1:0]   position;
   modport source (output valid, found, position, input ready);
   modport sink   (input valid, found, position, output ready);
endinterface

interface search_csr_if;
   logic                             valid;
   logic                             ready;
   logic [tse_pkg::CSR_INDEX_W-1:0]  index;
   logic [tse_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/table_search_engine.sv */
// Top level of the table search engine: key table, search sequencer, result register.
// Depends on tse_pkg, the channel interfaces, tse_ram, tse_compare and tse_sequencer.
//
// Usage. Items arrive on req_chan. A write item stores its key at its address;
// addresses at or beyond DEPTH are ignored, and no result is produced. A search item
// (forward, reverse or binary) compares its key with the first table_length entries
// (saturated to DEPTH) and produces one result on rsp_chan: found, and the matching
// position, zero on a miss. csr_chan sets table_length (index 0) and compare_signed
// (index 1) and is always ready. Entries never written read as arbitrary values.
//
// Timing. A write item leaves the block ready. A linear search reads one entry per cycle
// through the single RAM read port and stops at the first match in visit order; a
// miss is reported once all entries of the used length have been read. A binary
// search runs each probe as a read state and then a compare state, with at most
// floor(log2(n)) + 1 probes for a used length n. req_chan.ready is low during a search
// and rises as its result enters the output register; if the receiver stalls, a
// finished search holds its result until the register frees up.
// Reset returns table_length to 256 and compare_signed to 0, empties the result
// register and idles the sequencer; it does not clear the table.
module table_search_engine #(
   parameter int DEPTH     = 256,
   parameter int KEY_WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   search_req_if.sink    req_chan,
   search_rsp_if.source  rsp_chan,
   search_csr_if.sink    csr_chan
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = tse_pkg::POSITION_W;

   // Configuration registers.
   logic [tse_pkg::LENGTH_W-1:0] table_length_ff;
   logic                         compare_signed_ff;

   // Search key held for the whole search.
   logic [KEY_WIDTH-1:0]         key_ff;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [PW-1:0]                rsp_pos_ff, rsp_pos_in;

   // Set while a search runs or waits to hand over its result.
   logic                         seq_busy_ff;

   logic                         seq_idle;
   logic                         req_accept;
   logic                         is_write;
   logic                         write_en;
   logic                         search_start;
   logic [CW-1:0]                used_length;
   logic [AW-1:0]                rd_addr;
   logic [KEY_WIDTH-1:0]         rd_data;
   tse_pkg::cmp_type             cmp;
   tse_pkg::status_type          status;
   logic [AW-1:0]                hit_index;
   logic                         take;

   // The sequencer only reports done while a search has finished; it is idle
   // whenever it takes new work, which the ready below mirrors.
   assign req_chan.ready = seq_idle;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign is_write       = tse_pkg::op_type'(req_chan.operation) == tse_pkg::OP_WRITE;
   assign write_en       = req_accept && is_write &&
                           (32'(req_chan.address) < 32'(DEPTH));
   assign search_start   = req_accept && !is_write;

   // Lengths above the table size saturate to the table size.
   assign used_length = (32'(table_length_ff) > 32'(DEPTH)) ? CW'(DEPTH)
                                                            : CW'(table_length_ff);

   // Configuration writes; indexes beyond the register list do nothing.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff   <= tse_pkg::LENGTH_RESET;
         compare_signed_ff <= 1'b0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            tse_pkg::REG_TABLE_LENGTH: begin
               table_length_ff <= csr_chan.data[tse_pkg::LENGTH_W-1:0];
            end
            tse_pkg::REG_COMPARE_SIGNED: begin
               compare_signed_ff <= csr_chan.data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (search_start) begin
         key_ff <= KEY_WIDTH'(req_chan.key);
      end
   end

   tse_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (DEPTH)
   ) u_key_table (
      .clock (clock),
      .we    (write_en),
      .waddr (AW'(req_chan.address)),
      .wdata (KEY_WIDTH'(req_chan.key)),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   tse_compare #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_compare (
      .entry     (rd_data),
      .key       (key_ff),
      .is_signed (compare_signed_ff),
      .result    (cmp)
   );

   tse_sequencer #(
      .DEPTH (DEPTH)
   ) u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (search_start),
      .start_op  (tse_pkg::op_type'(req_chan.operation)),
      .length    (used_length),
      .cmp       (cmp),
      .take      (take),
      .rd_addr   (rd_addr),
      .status    (status),
      .hit_index (hit_index)
   );

   // The idle state is the only one without a finished or running search.
   assign seq_idle = !status.done && (seq_busy_ff == 1'b0);

   // A finished result moves into the output register once it is free.
   assign take = status.done && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = status.found;
         rsp_pos_in   = status.found ? PW'(hit_index) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.position = rsp_pos_ff;

   // Busy tracking: set when a search starts, cleared when its result is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_busy_ff <= 1'b0;
      end else if (search_start) begin
         seq_busy_ff <= 1'b1;
      end else if (take) begin
         seq_busy_ff <= 1'b0;
      end
   end

`ifndef SYNTHESIS
   // A search item takes the block out of the ready state.
   a_search_blocks: assert property (@(posedge clock) disable iff (reset)
      search_start |=> !req_chan.ready)
      else $error("search accepted but block still ready");

   // A write item leaves the block ready in the next cycle.
   a_write_ready: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_write) |=> req_chan.ready)
      else $error("write item stalled the block");

   // A miss always reports position zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_pos_ff == '0))
      else $error("miss with nonzero position");

   // A new result appears only after the sequencer reported a finished search.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> $past(status.done))
      else $error("result without a finished search");
`endif

endmodule

/* rtl/tse_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Stands alone; no package needed.
module tse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/tse_compare.sv */
// Shared three-way key comparator, unsigned or two's complement signed.
// Depends on tse_pkg for the result struct.
module tse_compare #(
   parameter int KEY_WIDTH = 32
) (
   input  logic [KEY_WIDTH-1:0] entry,
   input  logic [KEY_WIDTH-1:0] key,
   input  logic                 is_signed,
   output tse_pkg::cmp_type     result
);

   localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

   logic [KEY_WIDTH-1:0] entry_ord;
   logic [KEY_WIDTH-1:0] key_ord;

   // Flipping the sign bit maps signed order onto unsigned order.
   assign entry_ord    = entry ^ (is_signed ? SIGN_BIT : '0);
   assign key_ord      = key ^ (is_signed ? SIGN_BIT : '0);
   assign result.less  = entry_ord < key_ord;
   assign result.equal = entry_ord == key_ord;

endmodule

/* rtl/tse_sequencer.sv */
// Search sequencer: walks the table linearly or bisects it, one RAM read per step.
// Depends on tse_pkg for operation codes, comparator result and status types.
module tse_sequencer #(
   parameter int DEPTH = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  tse_pkg::op_type              start_op,
   input  logic [$clog2(DEPTH+1)-1:0]   length,
   input  tse_pkg::cmp_type             cmp,
   input  logic                         take,
   output logic [$clog2(DEPTH)-1:0]     rd_addr,
   output tse_pkg::status_type          status,
   output logic [$clog2(DEPTH)-1:0]     hit_index
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_SCAN   = 5'b00010,
      S_PROBE  = 5'b00100,
      S_CHECK  = 5'b01000,
      S_REPORT = 5'b10000
   } state_type;

   state_type       state_ff, state_in;
   tse_pkg::op_type mode_ff, mode_in;
   logic [AW-1:0]   cur_ff, cur_in;
   logic [CW-1:0]   left_ff, left_in;
   logic            pend_ff, pend_in;
   logic [AW-1:0]   pidx_ff, pidx_in;
   logic [CW-1:0]   lo_ff, lo_in;
   logic [CW-1:0]   end_ff, end_in;
   logic            found_ff, found_in;
   logic [AW-1:0]   idx_ff, idx_in;

   logic            issue;
   logic [CW-1:0]   span;
   logic [CW-1:0]   mid_wide;
   logic [AW-1:0]   mid;

   // The open interval [lo, end) stands for the closed [lo, end - 1].
   assign span     = end_ff - lo_ff - CW'(1);
   assign mid_wide = lo_ff + (span >> 1);
   assign mid      = AW'(mid_wide);
   assign issue    = left_ff != '0;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cur_in   = cur_ff;
      left_in  = left_ff;
      pend_in  = 1'b0;
      pidx_in  = pidx_ff;
      lo_in    = lo_ff;
      end_in   = end_ff;
      found_in = found_ff;
      idx_in   = idx_ff;
      rd_addr  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = start_op;
               cur_in  = (start_op == tse_pkg::OP_REVERSE) ? AW'(length - CW'(1)) : '0;
               left_in = length;
               lo_in   = '0;
               end_in  = length;
               state_in = (start_op == tse_pkg::OP_BINARY) ? S_PROBE : S_SCAN;
            end
         end
         S_SCAN: begin
            // Read one entry per cycle; compare the one whose read was issued in the previous cycle.
            rd_addr = cur_ff;
            if (issue) begin
               cur_in  = (mode_ff == tse_pkg::OP_REVERSE) ? cur_ff - AW'(1) : cur_ff + AW'(1);
               left_in = left_ff - CW'(1);
               pend_in = 1'b1;
               pidx_in = cur_ff;
            end
            if (pend_ff && cmp.equal) begin
               found_in = 1'b1;
               idx_in   = pidx_ff;
               state_in = S_REPORT;
            end else if (!issue && !pend_ff) begin
               found_in = 1'b0;
               state_in = S_REPORT;
            end
         end
         S_PROBE: begin
            rd_addr = mid;
            if (lo_ff < end_ff) begin
               pidx_in  = mid;
               state_in = S_CHECK;
            end else begin
               found_in = 1'b0;
               state_in = S_REPORT;
            end
         end
         S_CHECK: begin
            if (cmp.equal) begin
               found_in = 1'b1;
               idx_in   = pidx_ff;
               state_in = S_REPORT;
            end else begin
               if (cmp.less) begin
                  lo_in = CW'(pidx_ff) + CW'(1);
               end else begin
                  end_in = CW'(pidx_ff);
               end
               state_in = S_PROBE;
            end
         end
         S_REPORT: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
      mode_ff  <= mode_in;
      cur_ff   <= cur_in;
      left_ff  <= left_in;
      pidx_ff  <= pidx_in;
      lo_ff    <= lo_in;
      end_ff   <= end_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
   end

   assign status.done  = state_ff == S_REPORT;
   assign status.found = found_ff;
   assign hit_index    = idx_ff;

endmodule
